// ----- rtl/sensor_debounce_event_gen_macros.svh -----
// ----------------------------------------------------------------------------
// sensor_debounce_event_gen_macros.svh
// assertion macros shared by the sensor debounce checker
// ----------------------------------------------------------------------------
`ifndef SENSOR_DEBOUNCE_EVENT_GEN_MACROS_SVH
`define SENSOR_DEBOUNCE_EVENT_GEN_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SDEG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SDEG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sdeg_pkg.sv -----
// ----------------------------------------------------------------------------
// sdeg_pkg
// shared types and constants of the sensor debounce event generator
// ----------------------------------------------------------------------------
package sdeg_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int WORD_W    = 4;
    localparam int CONTACT_W = 16;
    localparam int IDENT_W   = 22;
    localparam int DEVICE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int POS_W     = 5;

    localparam logic [IDENT_W-1:0] FRAME_BASE = 22'h220300;

    // register indexes on the configuration port
    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_DEVICE = 2'd1;
    localparam logic [1:0] REG_HASH   = 2'd2;

    // queue between the classifier and the event emitter
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one classified word: which contacts toggled and their sampled levels
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] toggled;
    } sdeg_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sdeg_qstat_t;

    // per-word debounce state, debounced level kept inverted
    typedef struct packed {
        logic [SAMPLE_W-1:0] cnt_low;
        logic [SAMPLE_W-1:0] cnt_high;
        logic [SAMPLE_W-1:0] stable_inv;
    } sdeg_state_t;

endpackage

// ----- rtl/sensor_debounce_event_gen.sv -----
// ----------------------------------------------------------------------------
// sensor_debounce_event_gen
// debounces 32-contact sensor words and emits one event per changed contact
// ----------------------------------------------------------------------------
// Each accepted word goes through a 2-bit vertical counter per contact; a
// contact flips its debounced level after four samples in a row that differ
// from it, and every flip becomes one event, contacts taken from bit 31 down.
// The classifier takes a word through the accept with the read of the
// word-state ram, the write-back, and the hand-off to a two-entry queue,
// which waits while the queue is full; words with an index at or above
// NUM_WORDS are taken and dropped without leaving idle. The emitter drains
// the queue at one event per cycle while the output is not stalled, loading
// each word before its first event. The word-state ram starts out as all
// ones through one valid bit per word, so no clearing pass follows reset.
// Configuration lives at byte addresses 0 (contact offset), 4 (device id) and
// 8 (frame hash), 16 bits each; write it only while no events are pending.
module sensor_debounce_event_gen #(
    parameter int NUM_WORDS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sdeg_pkg::WORD_W-1:0]     word_index,
    input  logic [sdeg_pkg::SAMPLE_W-1:0]   sample_bits,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sdeg_pkg::IDENT_W-1:0]    frame_ident,
    output logic [sdeg_pkg::DEVICE_W-1:0]   event_device,
    output logic [sdeg_pkg::CONTACT_W-1:0]  contact_number,
    output logic                            new_level,
    output logic                            last_event
);
    import sdeg_pkg::*;

    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] device_reg;
    logic [CFG_W-1:0] hash_reg;
    logic             cfg_write;
    logic [1:0]       reg_sel;

    logic        q_push;
    logic        q_pop;
    sdeg_item_t  q_push_item;
    sdeg_item_t  q_pop_item;
    sdeg_qstat_t q_stat;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            device_reg <= '0;
            hash_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_OFFSET: offset_reg <= pwdata[CFG_W-1:0];
                REG_DEVICE: device_reg <= pwdata[CFG_W-1:0];
                REG_HASH:   hash_reg   <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_OFFSET: prdata = 32'(offset_reg);
            REG_DEVICE: prdata = 32'(device_reg);
            REG_HASH:   prdata = 32'(hash_reg);
            default:    prdata = '0;
        endcase
    end

    sdeg_front #(
        .NUM_WORDS (NUM_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .word_index  (word_index),
        .sample_bits (sample_bits),
        .q_push      (q_push),
        .q_item      (q_push_item),
        .q_stat      (q_stat)
    );

    sdeg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .stat      (q_stat)
    );

    sdeg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (q_pop_item),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .contact_offset (offset_reg),
        .device_id      (device_reg),
        .frame_hash     (hash_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_ident    (frame_ident),
        .event_device   (event_device),
        .contact_number (contact_number),
        .new_level      (new_level),
        .last_event     (last_event)
    );

endmodule

// ----- rtl/sdeg_front.sv -----
// ----------------------------------------------------------------------------
// sdeg_front
// accepts sample words, runs the vertical counters from the word-state ram
// and hands words with toggled contacts to the queue
// ----------------------------------------------------------------------------
module sdeg_front #(
    parameter int NUM_WORDS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sdeg_pkg::WORD_W-1:0]  word_index,
    input  logic [sdeg_pkg::SAMPLE_W-1:0] sample_bits,
    output logic                         q_push,
    output sdeg_pkg::sdeg_item_t         q_item,
    input  sdeg_pkg::sdeg_qstat_t        q_stat
);
    import sdeg_pkg::*;

    localparam int WIDX = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    sdeg_state_t mem [NUM_WORDS];
    sdeg_state_t rd_data_reg;
    sdeg_state_t cur_state;
    sdeg_state_t wr_data;

    logic [NUM_WORDS-1:0] ent_valid_reg;
    logic                 rd_valid_reg;
    logic [WIDX-1:0]      addr_in;
    logic [WIDX-1:0]      addr_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [SAMPLE_W-1:0]  toggled_reg;
    logic [SAMPLE_W-1:0]  diff;
    logic [SAMPLE_W-1:0]  lo;
    logic [SAMPLE_W-1:0]  hi;
    logic [SAMPLE_W-1:0]  toggled;
    logic                 accept;
    logic                 in_range;
    logic                 mem_we;

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = (word_index < NUM_WORDS);
    assign addr_in  = WIDX'(word_index);
    assign mem_we   = (state_reg == F_READ);

    // never-written words read as the reset pattern
    assign cur_state = rd_valid_reg ? rd_data_reg : '1;

    always_comb
    begin
        diff    = cur_state.stable_inv ^ ~sample_reg;
        lo      = ~(cur_state.cnt_low & diff);
        hi      = lo ^ (cur_state.cnt_high & diff);
        toggled = diff & lo & hi;
        wr_data.cnt_low    = lo;
        wr_data.cnt_high   = hi;
        wr_data.stable_inv = cur_state.stable_inv ^ toggled;
    end

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && in_range)
                    state_next = F_READ;
            end
            F_READ:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (toggled_reg == '0)
                    state_next = F_IDLE;
                else if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_item.word    = word_reg;
    assign q_item.sample  = sample_reg;
    assign q_item.toggled = toggled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            ent_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
                ent_valid_reg[addr_reg] <= 1'b1;
        end
    end

    // word-state ram, read at accept, written back in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= wr_data;
        if (accept && in_range)
            rd_data_reg <= mem[addr_in];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            rd_valid_reg <= ent_valid_reg[addr_in];
            addr_reg     <= addr_in;
            word_reg     <= word_index;
            sample_reg   <= sample_bits;
        end
        if (mem_we)
            toggled_reg <= toggled;
    end

endmodule

// ----- rtl/sdeg_fifo.sv -----
// ----------------------------------------------------------------------------
// sdeg_fifo
// short queue of classified words between classifier and event emitter
// ----------------------------------------------------------------------------
module sdeg_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sdeg_pkg::sdeg_item_t  push_item,
    input  logic                  pop,
    output sdeg_pkg::sdeg_item_t  pop_item,
    output sdeg_pkg::sdeg_qstat_t stat
);
    import sdeg_pkg::*;

    sdeg_item_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/sdeg_back.sv -----
// ----------------------------------------------------------------------------
// sdeg_back
// takes classified words from the queue and emits one event per toggled
// contact, highest bit first, through an output register
// ----------------------------------------------------------------------------
module sdeg_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sdeg_pkg::sdeg_item_t           q_item,
    input  sdeg_pkg::sdeg_qstat_t          q_stat,
    output logic                           q_pop,
    input  logic [sdeg_pkg::CFG_W-1:0]     contact_offset,
    input  logic [sdeg_pkg::CFG_W-1:0]     device_id,
    input  logic [sdeg_pkg::CFG_W-1:0]     frame_hash,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sdeg_pkg::IDENT_W-1:0]   frame_ident,
    output logic [sdeg_pkg::DEVICE_W-1:0]  event_device,
    output logic [sdeg_pkg::CONTACT_W-1:0] contact_number,
    output logic                           new_level,
    output logic                           last_event
);
    import sdeg_pkg::*;

    logic [SAMPLE_W-1:0]  mask_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [WORD_W-1:0]    word_reg;
    logic                 out_valid_reg;
    logic [IDENT_W-1:0]   ident_reg;
    logic [DEVICE_W-1:0]  device_reg;
    logic [CONTACT_W-1:0] contact_reg;
    logic                 level_reg;
    logic                 last_reg;

    logic [POS_W-1:0]     pos;
    logic [SAMPLE_W-1:0]  sel_bit;
    logic [SAMPLE_W-1:0]  mask_left;
    logic                 out_free;
    logic                 emit;
    logic                 busy;

    // position of the highest pending contact, counted from bit 31
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (mask_reg[i])
                pos = POS_W'(SAMPLE_W - 1 - i);
        end
    end

    assign sel_bit   = {1'b1, {(SAMPLE_W-1){1'b0}}} >> pos;
    assign mask_left = mask_reg & ~sel_bit;
    assign busy      = (mask_reg != '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = busy && out_free;
    assign q_pop     = !busy && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                mask_reg <= q_item.toggled;
            else if (emit)
                mask_reg <= mask_left;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= q_item.sample;
            word_reg   <= q_item.word;
        end
        if (emit)
        begin
            ident_reg   <= FRAME_BASE | IDENT_W'(frame_hash);
            device_reg  <= device_id;
            contact_reg <= contact_offset + CONTACT_W'({word_reg, {POS_W{1'b0}}})
                           + CONTACT_W'(pos) + CONTACT_W'(1);
            level_reg   <= |(sample_reg & sel_bit);
            last_reg    <= (mask_left == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_ident    = ident_reg;
    assign event_device   = device_reg;
    assign contact_number = contact_reg;
    assign new_level      = level_reg;
    assign last_event     = last_reg;

endmodule

// ----- rtl/sdeg_checker.sv -----
// ----------------------------------------------------------------------------
// sdeg_checker
// port-level checks of the sensor debounce event generator
// ----------------------------------------------------------------------------
`include "sensor_debounce_event_gen_macros.svh"

module sdeg_checker #(
    parameter int NUM_WORDS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [3:0]  word_index,
    input logic        out_valid,
    input logic        out_stall,
    input logic [21:0] frame_ident,
    input logic [15:0] contact_number,
    input logic        new_level,
    input logic        last_event
);

    // a stalled request stays offered
    `SDEG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "event dropped while stalled")

    // a stalled request keeps its payload
    `SDEG_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(contact_number) && $stable(new_level) && $stable(last_event), "event changed while stalled")

    // fixed part of the frame identifier is always present
    `SDEG_ASSERT_IMP(a_ident_base, out_valid, frame_ident[21:16] == 6'h22 && frame_ident[9:8] == 2'b11, "frame identifier base missing")

    // a word in range keeps the classifier busy for its ram write-back
    `SDEG_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall && (word_index < NUM_WORDS), in_stall, "word taken without ram cycle")

endmodule

bind sensor_debounce_event_gen sdeg_checker #(
    .NUM_WORDS (NUM_WORDS)
) u_sdeg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .word_index     (word_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_ident    (frame_ident),
    .contact_number (contact_number),
    .new_level      (new_level),
    .last_event     (last_event)
);
